### hdl/osel_pkg.sv
`default_nettype none

package osel_pkg;

    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 6;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_SELECT
    } osel_state_t;

    // Control broadcast to every cell of the row.
    typedef struct packed
    {
        logic insert;   // place the new word into sorted position
        logic shift;    // move every word one cell toward cell 0
        logic clear;    // drop all words
    } osel_ctrl_t;

endpackage

`default_nettype wire

### hdl/osel_cell.sv
`default_nettype none

module osel_cell
    import osel_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire osel_ctrl_t           ctrl,
    input  wire logic signed [VALUE_W-1:0] new_value,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire                       left_valid,
    input  wire                       left_gt,
    input  wire logic signed [VALUE_W-1:0] right_value,
    input  wire                       right_valid,
    output logic signed [VALUE_W-1:0] value,
    output logic                      valid,
    output logic                      gt
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;

    // New word belongs at or before this cell.
    assign gt = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.insert && gt)
        begin
            if (left_gt)
            begin
                // Make room: take the left neighbor's word.
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

### hdl/order_statistic_select.sv
`default_nettype none

// Order statistic select: load a set of signed 32-bit words, one per start
// pulse, and get back the word at the requested 0-based ascending rank when
// the word marked last arrives. Words stream in at one per cycle while busy is
// low: a row of MAX_ITEMS cells keeps the set sorted as it loads, each new word
// dropping into place in the cycle it is taken. The last word is stored first;
// busy then rises and, unless the status is an error, the row shifts toward
// cell 0 once per cycle until the wanted word sits in cell 0; busy then falls
// and done pulses in that same cycle. A new set may start in that same cycle.
// done is high for exactly one cycle and cannot be held off, so capture
// selected and status when it is seen. Words that arrive with the row full
// are dropped; the drop is reported as status 2 (with selected zero) at the
// next readout, which takes precedence over a rank at or beyond the word
// count (status 1, selected zero). Every readout empties the set.

module order_statistic_select
    import osel_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire                        last,
    input  wire logic [RANK_W-1:0]     rank,
    output logic                       done,
    output logic signed [VALUE_W-1:0]  selected,
    output logic [STATUS_W-1:0]        status
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    osel_state_t state_reg;
    osel_state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    logic                      done_reg;
    logic                      done_next;
    logic signed [VALUE_W-1:0] selected_reg;
    logic signed [VALUE_W-1:0] selected_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;

    osel_ctrl_t ctrl;
    logic       accept;
    logic       has_room;
    logic       bad_rank;
    logic       emit;

    logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic                      cell_valid [MAX_ITEMS];
    logic                      cell_gt    [MAX_ITEMS];

    assign accept   = start && (state_reg == ST_IDLE);
    assign has_room = (count_reg < CNT_MAX);
    assign bad_rank = (CMP_W'(rank_reg) >= CMP_W'(count_reg));

    // Row of sorting cells; cell 0 holds the smallest word.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_valid;
        logic                      left_gt;
        logic signed [VALUE_W-1:0] right_value;
        logic                      right_valid;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b0;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        osel_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_value   (value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        ctrl          = '0;
        emit          = 1'b0;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        rank_next     = rank_reg;
        done_next     = 1'b0;
        selected_next = selected_reg;
        status_next   = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Store the word, or remember the drop when full.
                    if (has_room)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        rank_next = rank;
                    end
                end
            end
            ST_SELECT:
            begin
                if (ovf_reg)
                begin
                    emit          = 1'b1;
                    selected_next = '0;
                    status_next   = STATUS_DROPPED;
                end
                else if (bad_rank)
                begin
                    emit          = 1'b1;
                    selected_next = '0;
                    status_next   = STATUS_BAD_RANK;
                end
                else if (rank_reg == '0)
                begin
                    emit          = 1'b1;
                    selected_next = cell_value[0];
                    status_next   = STATUS_OK;
                end
                else
                begin
                    // Advance the wanted word one cell toward the head.
                    ctrl.shift = 1'b1;
                    rank_next  = rank_reg - 1'b1;
                end
                if (emit)
                begin
                    // Drop the set so the next word starts a new one.
                    ctrl.clear = 1'b1;
                    done_next  = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg     <= rank_next;
        selected_reg <= selected_next;
        status_reg   <= status_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign selected = selected_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire
